FILE: hw/rtl/lzd_pkg.sv
// shared types and constants for the lzss inverted byte decoder
`timescale 1ns / 1ps

package lzd_pkg;

    // window geometry and token format
    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MAX_REF         = 18;
    localparam int MIN_REF         = 3;
    localparam int BYTE_W          = 8;
    localparam int CNT_W           = 24;
    localparam int LEN_W           = $clog2(MAX_REF + 1);
    localparam int BUF_AW          = $clog2(MAX_REF);

    // configuration register indexes
    typedef enum logic {
        CFG_SKIP_COUNT   = 1'b0,
        CFG_OUTPUT_LIMIT = 1'b1
    } lzd_cfg_idx_t;

    // position in the compressed byte stream
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_HIGH  = 2'd2
    } lzd_phase_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECODE = 2'd1,
        ST_READ   = 2'd2,
        ST_WRITE  = 2'd3
    } lzd_state_t;

    // window control from the sequencer
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } lzd_win_ctl_t;

endpackage

FILE: hw/rtl/lzd_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/lzd_window.sv
// history window: ram, write pointer and fill count that stands in for clearing
`timescale 1ns / 1ps

module lzd_window #(
    parameter int DEPTH = lzd_pkg::WINDOW_SIZE_DEF,
    parameter int START = lzd_pkg::WINDOW_SIZE_DEF - lzd_pkg::MAX_REF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lzd_pkg::lzd_win_ctl_t       ctl,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  logic [lzd_pkg::BYTE_W-1:0]  wr_data,
    output logic [lzd_pkg::BYTE_W-1:0]  rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0]             wp_reg;
    logic [AW-1:0]             wp_next;
    logic [AW:0]               fill_reg;
    logic [AW:0]               fill_next;
    logic                      hit_reg;
    logic [AW-1:0]             rd_off;
    logic                      rd_hit;
    logic [lzd_pkg::BYTE_W-1:0] ram_q;

    lzd_ram #(
        .WIDTH (lzd_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (wp_reg),
        .wdata (wr_data),
        .re    (ctl.rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // entries are written in order from START, so an entry holds data
    // once its distance from START is below the fill count
    assign rd_off = rd_addr - AW'(START);
    assign rd_hit = fill_reg[AW] | ({1'b0, rd_off} < fill_reg);

    // pointer and fill count update, stream open has priority
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            wp_next   = AW'(START);
            fill_next = '0;
        end
        else if (ctl.wr_en)
        begin
            wp_next = wp_reg + 1'b1;
            if (!fill_reg[AW])
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= AW'(START);
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            if (ctl.rd_en)
            begin
                hit_reg <= rd_hit;
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = hit_reg ? ram_q : '0;

    // fill count saturates at the window depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (AW+1)'(DEPTH))
        else $error("window fill count beyond depth");

    // pointer stays in step with the fill count until the window is full
    a_wp_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !fill_reg[AW] |-> (AW'(wp_reg - AW'(START)) == fill_reg[AW-1:0]))
        else $error("write pointer and fill count disagree");

    // a clear empties the window on the next cycle
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (fill_reg == '0) && !$past(ctl.wr_en))
        else $error("window clear overlapped a write");

endmodule

FILE: hw/rtl/lzss_inverted_byte_decoder.sv
// top level: lzss decoder sequencer, counters, reference buffer and output register
// flag, reference low byte and ignored bytes end in the decode state; a literal is put
//   in the reference buffer there, then written back and output in the write state;
//   a reference of len bytes (3 to 18) is read in full, then written back; output stalls
//   hold the write state, and in_stall holds the next request until the current one ends
// reset: control clears asynchronously; the window reads as zero through a fill count,
//   so no clearing pass is needed after reset or at a stream start
`timescale 1ns / 1ps

module lzss_inverted_byte_decoder #(
    parameter int WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lzd_pkg::BYTE_W-1:0] in_byte,
    input  logic                       first_of_stream,
    input  logic                       last_of_stream,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lzd_pkg::BYTE_W-1:0] out_byte,
    output logic                       last_of_run,
    output logic [lzd_pkg::CNT_W-1:0]  produced_total,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [lzd_pkg::CNT_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(WINDOW_SIZE);
    localparam int START = WINDOW_SIZE - lzd_pkg::MAX_REF;

    // configuration
    logic [lzd_pkg::CNT_W-1:0]  skip_count_reg;
    logic [lzd_pkg::CNT_W-1:0]  output_limit_reg;

    // sequencer and decode state
    lzd_pkg::lzd_state_t        state_reg, state_next;
    lzd_pkg::lzd_phase_t        phase_reg, phase_next;
    logic [7:0]                 flag_reg, flag_next;
    logic [2:0]                 bit_index_reg, bit_index_next;
    logic [7:0]                 pending_reg, pending_next;
    logic [lzd_pkg::CNT_W-1:0]  skip_left_reg, skip_left_next;
    logic [lzd_pkg::CNT_W-1:0]  out_left_reg, out_left_next;
    logic [lzd_pkg::CNT_W-1:0]  emitted_reg, emitted_next;
    logic [AW-1:0]              src_reg, src_next;
    logic [lzd_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [lzd_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic                       cap_reg;
    logic [lzd_pkg::BUF_AW-1:0] cap_idx_reg;

    // latched request
    logic [7:0]                 raw_reg;
    logic                       first_reg;
    logic                       last_reg;

    // reference buffer
    logic [7:0]                 buf_reg [lzd_pkg::MAX_REF];
    logic                       buf_we;
    logic [lzd_pkg::BUF_AW-1:0] buf_widx;
    logic [7:0]                 buf_wdata;

    // output register
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_last_reg;
    logic [lzd_pkg::CNT_W-1:0]  out_total_reg;
    logic                       out_load;
    logic                       out_last;
    logic                       slot_free;

    // window interface
    lzd_pkg::lzd_win_ctl_t      win_ctl;
    logic [AW-1:0]              win_rd_addr;
    logic [7:0]                 win_wr_data;
    logic [7:0]                 win_rd_data;

    // decode scratch
    logic [7:0]                 inv;
    lzd_pkg::lzd_phase_t        eff_phase;
    logic [7:0]                 eff_flag;
    logic [2:0]                 eff_bi;
    logic [7:0]                 eff_pending;
    logic [lzd_pkg::CNT_W-1:0]  eff_out_left;
    logic                       token_step;
    logic                       finish;
    logic                       deliver;
    logic [lzd_pkg::BUF_AW-1:0] rd_idx;

    lzd_window #(
        .DEPTH (WINDOW_SIZE),
        .START (START)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win_ctl),
        .rd_addr (win_rd_addr),
        .wr_data (win_wr_data),
        .rd_data (win_rd_data)
    );

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg   <= '0;
            output_limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (lzd_pkg::lzd_cfg_idx_t'(cfg_index))
                lzd_pkg::CFG_SKIP_COUNT:   skip_count_reg   <= cfg_data;
                lzd_pkg::CFG_OUTPUT_LIMIT: output_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall  = (state_reg != lzd_pkg::ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign inv       = ~raw_reg;
    assign rd_idx    = idx_reg[lzd_pkg::BUF_AW-1:0];

    // stream values as seen after an optional stream open
    always_comb
    begin
        if (first_reg)
        begin
            eff_phase    = lzd_pkg::PH_FLAG;
            eff_flag     = '0;
            eff_bi       = '0;
            eff_pending  = '0;
            eff_out_left = output_limit_reg;
        end
        else
        begin
            eff_phase    = phase_reg;
            eff_flag     = flag_reg;
            eff_bi       = bit_index_reg;
            eff_pending  = pending_reg;
            eff_out_left = out_left_reg;
        end
    end

    // sequencer next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        bit_index_next = bit_index_reg;
        pending_next   = pending_reg;
        skip_left_next = skip_left_reg;
        out_left_next  = out_left_reg;
        emitted_next   = emitted_reg;
        src_next       = src_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        win_ctl        = '0;
        win_rd_addr    = src_reg;
        win_wr_data    = buf_reg[rd_idx];
        buf_we         = cap_reg;
        buf_widx       = cap_idx_reg;
        buf_wdata      = win_rd_data;
        out_load       = 1'b0;
        out_last       = 1'b0;
        token_step     = 1'b0;
        finish         = 1'b0;
        deliver        = 1'b0;

        unique case (state_reg)
            lzd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lzd_pkg::ST_DECODE;
                end
            end

            lzd_pkg::ST_DECODE:
            begin
                // stream open resets window and counters
                if (first_reg)
                begin
                    win_ctl.clear  = 1'b1;
                    phase_next     = lzd_pkg::PH_FLAG;
                    flag_next      = '0;
                    bit_index_next = '0;
                    pending_next   = '0;
                    skip_left_next = skip_count_reg;
                    out_left_next  = output_limit_reg;
                    emitted_next   = '0;
                end
                finish = 1'b1;
                if (eff_out_left != '0)
                begin
                    case (eff_phase)
                        lzd_pkg::PH_FLAG:
                        begin
                            flag_next      = raw_reg;
                            bit_index_next = '0;
                            phase_next     = lzd_pkg::PH_TOKEN;
                        end
                        lzd_pkg::PH_TOKEN:
                        begin
                            if (eff_flag[eff_bi])
                            begin
                                pending_next = inv;
                                phase_next   = lzd_pkg::PH_HIGH;
                            end
                            else
                            begin
                                // literal goes through the write-back path as one byte
                                buf_we     = 1'b1;
                                buf_widx   = '0;
                                buf_wdata  = inv;
                                len_next   = lzd_pkg::LEN_W'(1);
                                idx_next   = '0;
                                state_next = lzd_pkg::ST_WRITE;
                                token_step = 1'b1;
                                finish     = 1'b0;
                            end
                        end
                        lzd_pkg::PH_HIGH:
                        begin
                            src_next   = AW'({inv[7:4], eff_pending});
                            len_next   = lzd_pkg::LEN_W'(raw_reg[3:0])
                                       + lzd_pkg::LEN_W'(lzd_pkg::MIN_REF);
                            idx_next   = '0;
                            state_next = lzd_pkg::ST_READ;
                            token_step = 1'b1;
                            finish     = 1'b0;
                        end
                        default: ;
                    endcase
                end
                if (token_step)
                begin
                    bit_index_next = eff_bi + 1'b1;
                    phase_next     = (bit_index_next == '0) ? lzd_pkg::PH_FLAG
                                                            : lzd_pkg::PH_TOKEN;
                end
                if (finish)
                begin
                    state_next = lzd_pkg::ST_IDLE;
                end
            end

            lzd_pkg::ST_READ:
            begin
                // fetch every reference byte before any write-back
                win_ctl.rd_en = 1'b1;
                src_next      = src_reg + 1'b1;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == len_reg - 1'b1)
                begin
                    idx_next   = '0;
                    state_next = lzd_pkg::ST_WRITE;
                end
            end

            lzd_pkg::ST_WRITE:
            begin
                // write back one byte and pass it through skip and limit
                deliver = (out_left_reg != '0) && (skip_left_reg == '0);
                if (!deliver || slot_free)
                begin
                    win_ctl.wr_en = 1'b1;
                    if (out_left_reg != '0)
                    begin
                        if (skip_left_reg != '0)
                        begin
                            skip_left_next = skip_left_reg - 1'b1;
                        end
                        else
                        begin
                            out_left_next = out_left_reg - 1'b1;
                            emitted_next  = emitted_reg + 1'b1;
                            out_load      = 1'b1;
                            out_last      = (idx_reg == len_reg - 1'b1)
                                         || (out_left_next == '0);
                        end
                    end
                    if (idx_reg == len_reg - 1'b1)
                    begin
                        finish     = 1'b1;
                        state_next = lzd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            default: ;
        endcase

        // end of stream closes it and drops any partial token
        if (finish && last_reg)
        begin
            phase_next     = lzd_pkg::PH_FLAG;
            bit_index_next = '0;
            out_left_next  = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzd_pkg::ST_IDLE;
            phase_reg     <= lzd_pkg::PH_FLAG;
            flag_reg      <= '0;
            bit_index_reg <= '0;
            pending_reg   <= '0;
            skip_left_reg <= '0;
            out_left_reg  <= '0;
            emitted_reg   <= '0;
            src_reg       <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            cap_reg       <= 1'b0;
            cap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            bit_index_reg <= bit_index_next;
            pending_reg   <= pending_next;
            skip_left_reg <= skip_left_next;
            out_left_reg  <= out_left_next;
            emitted_reg   <= emitted_next;
            src_reg       <= src_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            cap_reg       <= win_ctl.rd_en;
            cap_idx_reg   <= rd_idx;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            raw_reg   <= in_byte;
            first_reg <= first_of_stream;
            last_reg  <= last_of_stream;
        end
    end

    // reference buffer fill
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_reg[buf_widx] <= buf_wdata;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg  <= win_wr_data;
            out_last_reg  <= out_last;
            out_total_reg <= emitted_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_of_run    = out_last_reg;
    assign produced_total = out_total_reg;

    // output budget only grows when a stream opens
    a_budget: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == lzd_pkg::ST_DECODE && first_reg)
        |=> out_left_reg <= $past(out_left_reg))
        else $error("output budget grew without a stream open");

    // each emitted byte carries the running count
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid && (produced_total == emitted_reg))
        else $error("produced total out of step with emitted count");

    // read and write-back index stays inside the current run
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzd_pkg::ST_WRITE || state_reg == lzd_pkg::ST_READ)
        |-> idx_reg < len_reg)
        else $error("run index beyond run length");

    // references always span at least the minimum length
    a_ref_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lzd_pkg::ST_READ
        |-> len_reg >= lzd_pkg::LEN_W'(lzd_pkg::MIN_REF))
        else $error("reference shorter than minimum");

endmodule
